/* design/rpd_pkg.sv */
// ----------------------------------------------------------------------------
// RC PWM pulse decoder package
// Shared widths, reset values, register map, codes and sequencer states.
// ----------------------------------------------------------------------------
package rpd_pkg;

  localparam int unsigned NUM_CH      = 3;
  localparam int unsigned CH_FWD_BACK = 0;
  localparam int unsigned CH_LR       = 1;
  localparam int unsigned CH_THROTTLE = 2;

  localparam int unsigned WIDTH_W  = 12;
  localparam int unsigned MS_W     = 16;
  localparam int unsigned PCT_W    = 7;
  localparam int unsigned OFFSET_W = WIDTH_W + 1;
  localparam int unsigned NUM_W    = WIDTH_W + PCT_W;      // x * 100 fits here
  localparam int unsigned DSR_W    = WIDTH_W + PCT_W - 1;  // divisor shifted up
  localparam int unsigned ITER_W   = 3;

  localparam int unsigned APB_DW = 32;
  localparam int unsigned APB_AW = 5;

  localparam logic [WIDTH_W-1:0] WIDTH_MAX = '1;
  localparam logic [MS_W-1:0]    MS_MAX    = '1;
  localparam logic [PCT_W-1:0]   PCT_FULL  = PCT_W'(100);
  localparam logic [PCT_W-1:0]   PCT_ZERO  = '0;

  localparam logic [WIDTH_W-1:0] LR_NORMAL_DEADZONE = WIDTH_W'(50);
  localparam logic [WIDTH_W-1:0] LR_CONFIG_DEADZONE = WIDTH_W'(200);

  // Register reset values
  localparam logic [WIDTH_W-1:0] MIN_PULSE_RST   = WIDTH_W'(900);
  localparam logic [WIDTH_W-1:0] MAX_PULSE_RST   = WIDTH_W'(2100);
  localparam logic [WIDTH_W-1:0] IDLE_THR_RST    = WIDTH_W'(1100);
  localparam logic [WIDTH_W-1:0] FULL_THR_RST    = WIDTH_W'(1900);
  localparam logic [WIDTH_W-1:0] CENTER_FB_RST   = WIDTH_W'(1500);
  localparam logic [WIDTH_W-1:0] FB_MARGIN_RST   = WIDTH_W'(100);
  localparam logic [WIDTH_W-1:0] CENTER_LR_RST   = WIDTH_W'(1500);
  localparam logic [MS_W-1:0]    TIMEOUT_MS_RST  = MS_W'(1000);

  typedef enum logic [2:0] {
    REG_MIN_PULSE   = 3'd0,
    REG_MAX_PULSE   = 3'd1,
    REG_IDLE_THR    = 3'd2,
    REG_FULL_THR    = 3'd3,
    REG_CENTER_FB   = 3'd4,
    REG_FB_MARGIN   = 3'd5,
    REG_CENTER_LR   = 3'd6,
    REG_TIMEOUT_MS  = 3'd7
  } rpd_reg_e;

  typedef enum logic [1:0] {
    DIR_NEUTRAL  = 2'd0,
    DIR_FORWARD  = 2'd1,
    DIR_BACKWARD = 2'd2
  } rpd_dir_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } rpd_state_e;

  // Request into the percent divider
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [WIDTH_W-1:0] den;
  } rpd_div_req_t;

  // Status back from the percent divider
  typedef struct packed {
    logic             done;
    logic [PCT_W-1:0] quot;
  } rpd_div_rsp_t;

endpackage

/* design/rpd_div.sv */
// ----------------------------------------------------------------------------
// RC PWM pulse decoder percent divider
// Restoring divider, one quotient bit per cycle; quotient known below 128.
// ----------------------------------------------------------------------------
module rpd_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rpd_pkg::rpd_div_req_t req_i,
  output rpd_pkg::rpd_div_rsp_t rsp_o
);

  logic [rpd_pkg::NUM_W-1:0]  rem_q, rem_d;
  logic [rpd_pkg::DSR_W-1:0]  dsr_q, dsr_d;
  logic [rpd_pkg::PCT_W-1:0]  quo_q, quo_d;
  logic [rpd_pkg::ITER_W-1:0] cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic                       ge;

  assign ge = rem_q >= {1'b0, dsr_q};

  always_comb begin
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = req_i.num;
      dsr_d  = {req_i.den, (rpd_pkg::PCT_W-1)'(0)};
      quo_d  = '0;
      cnt_d  = rpd_pkg::ITER_W'(rpd_pkg::PCT_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // subtract when the shifted divisor fits, then move one bit down
      if (ge) begin
        rem_d = rem_q - {1'b0, dsr_q};
      end
      quo_d = {quo_q[rpd_pkg::PCT_W-2:0], ge};
      dsr_d = dsr_q >> 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

/* design/rc_pwm_pulse_decoder.sv */
// ----------------------------------------------------------------------------
// RC PWM pulse decoder
// Measures three RC servo pulse widths and reports throttle, direction,
// left/right offset, deadzone flags and link health.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): one transaction per microsecond
//   tick, carrying the three pin levels and a millisecond flag.
//   Output channel (out_valid_o / out_stall_i): exactly one result
//   transaction per input transaction, in order.
//   Configuration: APB-style port, registers at byte address 4*index, writes
//   only while no transaction is in flight. pready is tied high.
// Sequencing:
//   The throttle percent comes from one restoring divider that resolves
//   one quotient bit per cycle (7 bits). After acceptance the sequencer
//   steps through PREP, DIV and DONE; it skips DIV when the throttle width
//   sits at or beyond the idle or full point. One transaction is in work at
//   a time: the input stalls from acceptance until the result is loaded.
// Reset:
//   Clears all pin history and counters, loads register defaults and sets
//   latched widths to the default minimum pulse. No result is pending.
// Stall:
//   A finished result waits in the output register; the next input
//   transaction is still taken, but its result holds in the final step until
//   the output register frees up.
// ----------------------------------------------------------------------------
module rc_pwm_pulse_decoder (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,

  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 fwd_back_level_i,
  input  logic                                 left_right_level_i,
  input  logic                                 throttle_level_i,
  input  logic                                 ms_tick_i,

  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [rpd_pkg::PCT_W-1:0]            throttle_pct_o,
  output logic [1:0]                           direction_o,
  output logic signed [rpd_pkg::OFFSET_W-1:0]  lr_offset_o,
  output logic                                 lr_in_normal_deadzone_o,
  output logic                                 lr_in_config_deadzone_o,
  output logic                                 signal_healthy_o,

  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [rpd_pkg::APB_AW-1:0]           paddr,
  input  logic [rpd_pkg::APB_DW-1:0]           pwdata,
  output logic [rpd_pkg::APB_DW-1:0]           prdata,
  output logic                                 pready
);

  localparam int unsigned W  = rpd_pkg::WIDTH_W;
  localparam int unsigned NC = rpd_pkg::NUM_CH;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [W-1:0]              min_pulse_q, max_pulse_q, idle_thr_q, full_thr_q;
  logic [W-1:0]              center_fb_q, fb_margin_q, center_lr_q;
  logic [rpd_pkg::MS_W-1:0]  timeout_ms_q;
  logic                      cfg_wr;
  rpd_pkg::rpd_reg_e         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = rpd_pkg::rpd_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_pulse_q  <= rpd_pkg::MIN_PULSE_RST;
      max_pulse_q  <= rpd_pkg::MAX_PULSE_RST;
      idle_thr_q   <= rpd_pkg::IDLE_THR_RST;
      full_thr_q   <= rpd_pkg::FULL_THR_RST;
      center_fb_q  <= rpd_pkg::CENTER_FB_RST;
      fb_margin_q  <= rpd_pkg::FB_MARGIN_RST;
      center_lr_q  <= rpd_pkg::CENTER_LR_RST;
      timeout_ms_q <= rpd_pkg::TIMEOUT_MS_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        rpd_pkg::REG_MIN_PULSE:  min_pulse_q  <= pwdata[W-1:0];
        rpd_pkg::REG_MAX_PULSE:  max_pulse_q  <= pwdata[W-1:0];
        rpd_pkg::REG_IDLE_THR:   idle_thr_q   <= pwdata[W-1:0];
        rpd_pkg::REG_FULL_THR:   full_thr_q   <= pwdata[W-1:0];
        rpd_pkg::REG_CENTER_FB:  center_fb_q  <= pwdata[W-1:0];
        rpd_pkg::REG_FB_MARGIN:  fb_margin_q  <= pwdata[W-1:0];
        rpd_pkg::REG_CENTER_LR:  center_lr_q  <= pwdata[W-1:0];
        rpd_pkg::REG_TIMEOUT_MS: timeout_ms_q <= pwdata[rpd_pkg::MS_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back, zero-extended to the bus width
  always_comb begin
    unique case (cfg_idx)
      rpd_pkg::REG_MIN_PULSE:  prdata = rpd_pkg::APB_DW'(min_pulse_q);
      rpd_pkg::REG_MAX_PULSE:  prdata = rpd_pkg::APB_DW'(max_pulse_q);
      rpd_pkg::REG_IDLE_THR:   prdata = rpd_pkg::APB_DW'(idle_thr_q);
      rpd_pkg::REG_FULL_THR:   prdata = rpd_pkg::APB_DW'(full_thr_q);
      rpd_pkg::REG_CENTER_FB:  prdata = rpd_pkg::APB_DW'(center_fb_q);
      rpd_pkg::REG_FB_MARGIN:  prdata = rpd_pkg::APB_DW'(fb_margin_q);
      rpd_pkg::REG_CENTER_LR:  prdata = rpd_pkg::APB_DW'(center_lr_q);
      rpd_pkg::REG_TIMEOUT_MS: prdata = rpd_pkg::APB_DW'(timeout_ms_q);
      default:                 prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pulse measurement, one lane per pin, updated on the accepting edge
  // --------------------------------------------------------------------------
  rpd_pkg::rpd_state_e state_q, state_d;
  logic                in_accept;
  logic [NC-1:0]       level;
  logic [NC-1:0]       prev_q;
  logic [W-1:0]        cnt_q   [NC];
  logic [W-1:0]        latch_q [NC];
  logic [NC-1:0]       good;

  assign in_stall_o = (state_q != rpd_pkg::ST_IDLE);
  assign in_accept  = in_valid_i & ~in_stall_o;

  assign level[rpd_pkg::CH_FWD_BACK] = fwd_back_level_i;
  assign level[rpd_pkg::CH_LR]       = left_right_level_i;
  assign level[rpd_pkg::CH_THROTTLE] = throttle_level_i;

  for (genvar ch = 0; ch < NC; ch++) begin : g_lane
    // A falling edge with the width inside the window is a good pulse
    assign good[ch] = ~level[ch] & prev_q[ch] &
                      (cnt_q[ch] >= min_pulse_q) & (cnt_q[ch] <= max_pulse_q);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        prev_q[ch]  <= 1'b0;
        cnt_q[ch]   <= '0;
        latch_q[ch] <= rpd_pkg::MIN_PULSE_RST;
      end else if (in_accept) begin
        prev_q[ch] <= level[ch];
        if (level[ch]) begin
          // restart on a rising edge, otherwise count up and saturate
          if (!prev_q[ch]) begin
            cnt_q[ch] <= W'(1);
          end else if (cnt_q[ch] != rpd_pkg::WIDTH_MAX) begin
            cnt_q[ch] <= cnt_q[ch] + 1'b1;
          end
        end
        if (good[ch]) begin
          latch_q[ch] <= cnt_q[ch];
        end
      end
    end
  end

  // Link health: a good throttle pulse beats the millisecond tick
  logic [rpd_pkg::MS_W-1:0] ms_since_q;
  logic                     good_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_since_q  <= '0;
      good_seen_q <= 1'b0;
    end else if (in_accept) begin
      if (good[rpd_pkg::CH_THROTTLE]) begin
        ms_since_q  <= '0;
        good_seen_q <= 1'b1;
      end else if (ms_tick_i && ms_since_q != rpd_pkg::MS_MAX) begin
        ms_since_q <= ms_since_q + 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Throttle percent through the divider
  // --------------------------------------------------------------------------
  rpd_pkg::rpd_div_req_t div_req;
  rpd_pkg::rpd_div_rsp_t div_rsp;
  logic                      div_start;
  logic [rpd_pkg::NUM_W-1:0] div_num;
  logic [W-1:0]              div_den;
  logic [W-1:0]              thr_w;
  logic [W-1:0]              thr_x;
  logic [rpd_pkg::NUM_W-1:0] thr_x_ext;

  assign thr_w     = latch_q[rpd_pkg::CH_THROTTLE];
  assign thr_x     = thr_w - idle_thr_q;
  assign thr_x_ext = rpd_pkg::NUM_W'(thr_x);

  // x * 100 as x*64 + x*32 + x*4
  assign div_num = (thr_x_ext << 6) + (thr_x_ext << 5) + (thr_x_ext << 2);
  assign div_den = full_thr_q - idle_thr_q;
  assign div_req = '{start: div_start, num: div_num, den: div_den};

  rpd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // --------------------------------------------------------------------------
  // Result fields from the settled state
  // --------------------------------------------------------------------------
  logic signed [rpd_pkg::OFFSET_W-1:0]   fb_off, lr_off;
  logic signed [rpd_pkg::OFFSET_W:0]     fb_off_x, margin_x;
  logic [W-1:0]                          lr_mag;
  rpd_pkg::rpd_dir_e                     dir;

  assign fb_off   = $signed({1'b0, latch_q[rpd_pkg::CH_FWD_BACK]})
                  - $signed({1'b0, center_fb_q});
  assign lr_off   = $signed({1'b0, latch_q[rpd_pkg::CH_LR]})
                  - $signed({1'b0, center_lr_q});
  assign fb_off_x = (rpd_pkg::OFFSET_W+1)'(fb_off);
  assign margin_x = $signed({2'b00, fb_margin_q});
  assign lr_mag   = lr_off[rpd_pkg::OFFSET_W-1] ? W'(-lr_off) : W'(lr_off);

  always_comb begin
    if (fb_off_x > margin_x) begin
      dir = rpd_pkg::DIR_FORWARD;
    end else if (fb_off_x < -margin_x) begin
      dir = rpd_pkg::DIR_BACKWARD;
    end else begin
      dir = rpd_pkg::DIR_NEUTRAL;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer and output register
  // --------------------------------------------------------------------------
  logic [rpd_pkg::PCT_W-1:0]           pct_q, pct_d;
  logic                                out_valid_q, out_valid_d;
  logic                                out_load;
  logic [rpd_pkg::PCT_W-1:0]           tp_q;
  logic [1:0]                          dir_q;
  logic signed [rpd_pkg::OFFSET_W-1:0] lr_off_q;
  logic                                dz_norm_q, dz_cfg_q, healthy_q;

  always_comb begin
    state_d   = state_q;
    pct_d     = pct_q;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      rpd_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_d = rpd_pkg::ST_PREP;
        end
      end
      rpd_pkg::ST_PREP: begin
        // full test first, so an inverted range still gives 100 at the top
        if (thr_w >= full_thr_q) begin
          pct_d   = rpd_pkg::PCT_FULL;
          state_d = rpd_pkg::ST_DONE;
        end else if (thr_w <= idle_thr_q) begin
          pct_d   = rpd_pkg::PCT_ZERO;
          state_d = rpd_pkg::ST_DONE;
        end else begin
          div_start = 1'b1;
          state_d   = rpd_pkg::ST_DIV;
        end
      end
      rpd_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          pct_d   = div_rsp.quot;
          state_d = rpd_pkg::ST_DONE;
        end
      end
      rpd_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = rpd_pkg::ST_IDLE;
        end
      end
      default: state_d = rpd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rpd_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pct_q <= pct_d;
    if (out_load) begin
      tp_q      <= pct_q;
      dir_q     <= dir;
      lr_off_q  <= lr_off;
      dz_norm_q <= (lr_mag < rpd_pkg::LR_NORMAL_DEADZONE);
      dz_cfg_q  <= (lr_mag < rpd_pkg::LR_CONFIG_DEADZONE);
      healthy_q <= good_seen_q & (ms_since_q <= timeout_ms_q);
    end
  end

  assign out_valid_o             = out_valid_q;
  assign throttle_pct_o          = tp_q;
  assign direction_o             = dir_q;
  assign lr_offset_o             = lr_off_q;
  assign lr_in_normal_deadzone_o = dz_norm_q;
  assign lr_in_config_deadzone_o = dz_cfg_q;
  assign signal_healthy_o        = healthy_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> throttle_pct_o <= rpd_pkg::PCT_FULL)
    else $error("throttle percent above full scale");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == rpd_pkg::ST_DIV)
    else $error("divider finished outside the divide step");

  a_seen_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(good_seen_q))
    else $error("good pulse flag dropped without reset");

  a_load_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o && !in_stall_o)
    else $error("result load did not free the input");
`endif

endmodule
